/* hw/rtl/rop_pkg.sv */
// Shared types and constants for the ray / oriented-box nearest pick block.
// No dependencies.
package rop_pkg;

   localparam int EPS_Q30 = 10737;
   localparam logic signed [48:0] T_LIMIT = 49'sd65536000000;
   localparam logic [47:0] T_SAT_MAG = 48'h8000_0000_0000;

   typedef enum logic [2:0] {
      CSR_RAY_ORIGIN_X = 3'd0,
      CSR_RAY_ORIGIN_Y = 3'd1,
      CSR_RAY_ORIGIN_Z = 3'd2,
      CSR_RAY_DIR_X    = 3'd3,
      CSR_RAY_DIR_Y    = 3'd4,
      CSR_RAY_DIR_Z    = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIST_MUL,
      ST_DIST_ACC,
      ST_L2_MUL,
      ST_L2_ACC,
      ST_SQRT,
      ST_NORM_START,
      ST_NORM_WAIT,
      ST_NOM_MUL,
      ST_NOM_ACC,
      ST_DEN_MUL,
      ST_DEN_ACC,
      ST_SLAB_CHECK,
      ST_TDIV_START,
      ST_TDIV_WAIT,
      ST_SLAB_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        start;
      logic [5:0]  count;
      logic [46:0] rem_init;
      logic [46:0] low;
      logic [46:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic [46:0] quotient;
   } div_rsp_type;

endpackage

/* hw/rtl/rop_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the pick sequencer.
// Depends on rop_pkg (request/response structs).
module rop_div import rop_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic        busy_ff;
   logic [5:0]  cnt_ff;
   logic [46:0] rem_ff;
   logic [46:0] low_ff;
   logic [46:0] div_ff;
   logic [46:0] quo_ff;
   logic [47:0] cand;
   logic [48:0] diff;
   logic        qbit;

   assign cand = {rem_ff, low_ff[46]};
   assign diff = {1'b0, cand} - {2'b0, div_ff};
   assign qbit = ~diff[48];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= req.count;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.rem_init;
         low_ff <= req.low;
         div_ff <= req.divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= qbit ? diff[46:0] : cand[46:0];
         low_ff <= {low_ff[45:0], 1'b0};
         quo_ff <= {quo_ff[45:0], qbit};
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.quotient = quo_ff;

   property p_start_idle;
      @(posedge clock) disable iff (reset) req.start |-> !busy_ff;
   endproperty
   a_start_idle: assert property (p_start_idle) else $error("divider restarted while busy");

   property p_count_nonzero;
      @(posedge clock) disable iff (reset) req.start |-> req.count != 6'd0;
   endproperty
   a_count_nonzero: assert property (p_count_nonzero) else $error("divider started with no steps");

   property p_busy_ends;
      @(posedge clock) disable iff (reset) busy_ff && cnt_ff == 6'd1 |=> !busy_ff;
   endproperty
   a_busy_ends: assert property (p_busy_ends) else $error("divider overran its count");

endmodule

/* hw/rtl/ray_obb_nearest_pick_core.sv */
// Ray / oriented-box nearest pick: top level with APB register file and sequencer.
// Depends on rop_pkg and rop_div.
// Work per box: per slab there are three squared lengths and six numerator and denominator
// products on the shared 32x32 multiplier, a 20-step square root, and three 31-step
// normalising divisions and two 47-step slab divisions on the shared divider. The three-term
// centre distance comes first. A zero-length axis skips its normalising divisions, a
// parallel slab skips both slab divisions, and a saturated slab distance skips its own
// division. A slab that misses ends the box early. The block takes one box at a time; a
// finished result waits in the output register while the next box is processed, and the
// last box of a set stalls only if the previous result has not yet been taken.
module ray_obb_nearest_pick_core import rop_pkg::*; #(
   parameter int MAX_BOXES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_center_x,
   input  logic [31:0] req_center_y,
   input  logic [31:0] req_center_z,
   input  logic [59:0] req_half_extents,
   input  logic [59:0] req_axis_right,
   input  logic [59:0] req_axis_up,
   input  logic [59:0] req_axis_forward,
   input  logic        req_last_box,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit_found,
   output logic [5:0]  rsp_hit_index,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW = (MAX_BOXES > 2) ? $clog2(MAX_BOXES) : 1;
   localparam logic [CW-1:0] LAST_IDX = CW'(MAX_BOXES - 1);

   // registers
   logic signed [31:0] org_x_ff, org_y_ff, org_z_ff, dir_x_ff, dir_y_ff, dir_z_ff;
   csr_index_type      csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         org_z_ff <= '0;
         dir_x_ff <= '0;
         dir_y_ff <= '0;
         dir_z_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (csr_idx)
            CSR_RAY_ORIGIN_X: org_x_ff <= pwdata;
            CSR_RAY_ORIGIN_Y: org_y_ff <= pwdata;
            CSR_RAY_ORIGIN_Z: org_z_ff <= pwdata;
            CSR_RAY_DIR_X:    dir_x_ff <= pwdata;
            CSR_RAY_DIR_Y:    dir_y_ff <= pwdata;
            CSR_RAY_DIR_Z:    dir_z_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_RAY_ORIGIN_X: prdata = org_x_ff;
         CSR_RAY_ORIGIN_Y: prdata = org_y_ff;
         CSR_RAY_ORIGIN_Z: prdata = org_z_ff;
         CSR_RAY_DIR_X:    prdata = dir_x_ff;
         CSR_RAY_DIR_Y:    prdata = dir_y_ff;
         CSR_RAY_DIR_Z:    prdata = dir_z_ff;
         default:          prdata = '0;
      endcase
   end

   // datapath state
   state_type          state_ff, state_in;
   logic [1:0]         j_ff, k_ff;
   logic               side_ff;
   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic [59:0]        half_ff, ax_r_ff, ax_u_ff, ax_f_ff;
   logic               last_ff;
   logic [63:0]        prod_ff;
   logic [63:0]        dist_ff;
   logic [39:0]        l2_ff;
   logic [39:0]        sq_rad_ff;
   logic [21:0]        sq_rem_ff;
   logic [19:0]        sq_root_ff;
   logic [4:0]         sq_cnt_ff;
   logic [30:0]        u_mag_ff;
   logic               u_neg_ff;
   logic signed [49:0] nom_ff, den_ff;
   logic signed [48:0] tmin_ff, tmax_ff, t_lo_ff, t_hi_ff;
   logic               t_neg_ff;
   logic               hit_ff;
   logic [CW-1:0]      box_cnt_ff, best_idx_ff;
   logic [63:0]        best_dist_ff;
   logic               any_hit_ff;
   logic               rsp_valid_ff, rsp_found_ff;
   logic [5:0]         rsp_index_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   rop_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // operand selection
   logic signed [32:0] d_cur;
   logic [31:0]        d_mag;
   logic               d_neg;
   logic signed [31:0] dir_cur;
   logic [31:0]        dir_mag;
   logic [59:0]        axis_cur;
   logic signed [19:0] a_cur;
   logic [19:0]        a_mag;
   logic [19:0]        h_cur;
   logic [32:0]        d_abs;

   always_comb begin
      case (j_ff)
         2'd0:    begin d_cur = dx_ff; dir_cur = dir_x_ff; end
         2'd1:    begin d_cur = dy_ff; dir_cur = dir_y_ff; end
         default: begin d_cur = dz_ff; dir_cur = dir_z_ff; end
      endcase
      case (k_ff)
         2'd0:    begin axis_cur = ax_r_ff; h_cur = half_ff[19:0];  end
         2'd1:    begin axis_cur = ax_u_ff; h_cur = half_ff[39:20]; end
         default: begin axis_cur = ax_f_ff; h_cur = half_ff[59:40]; end
      endcase
      case (j_ff)
         2'd0:    a_cur = axis_cur[19:0];
         2'd1:    a_cur = axis_cur[39:20];
         default: a_cur = axis_cur[59:40];
      endcase
   end

   assign d_neg   = d_cur[32];
   assign d_abs   = d_neg ? -d_cur : d_cur;
   assign d_mag   = d_abs[31:0];
   assign dir_mag = dir_cur[31] ? 32'(-dir_cur) : 32'(dir_cur);
   assign a_mag   = a_cur[19] ? 20'(-a_cur) : 20'(a_cur);

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // square root step
   logic [23:0] sq_cand, sq_trial;
   logic        sq_ge;
   assign sq_cand  = {sq_rem_ff, sq_rad_ff[39:38]};
   assign sq_trial = {2'b0, sq_root_ff, 2'b01};
   assign sq_ge    = sq_cand >= sq_trial;

   // slab arithmetic
   logic signed [50:0] hq, nom_w, num, hq_neg;
   logic [50:0]        num_abs;
   logic [49:0]        n_mag;
   logic [49:0]        den_abs;
   logic [46:0]        den_mag;
   logic               den_big, t_sat, num_neg, par_miss;
   logic signed [48:0] t_sat_val, t_div_val, t_lo, t_hi, tmin_new, tmax_new;
   logic [49:0]        prod_hi;

   assign hq       = 51'(h_cur) <<< 22;
   assign hq_neg   = -hq;
   assign nom_w    = 51'(nom_ff);
   assign num      = side_ff ? nom_w + hq : nom_w - hq;
   assign num_neg  = num[50];
   assign num_abs  = num_neg ? -num : num;
   assign n_mag    = num_abs[49:0];
   assign den_abs  = den_ff[49] ? 50'(-den_ff) : 50'(den_ff);
   assign den_mag  = den_abs[46:0];
   assign den_big  = den_abs > 50'(EPS_Q30);
   assign t_sat    = {28'b0, n_mag} >= {den_mag, 31'b0};
   assign par_miss = (nom_w < hq_neg) || (nom_w > hq);
   assign t_sat_val = (num_neg ^ den_ff[49]) ? -$signed({1'b0, T_SAT_MAG})
                                              : $signed({1'b0, T_SAT_MAG});
   assign t_div_val = t_neg_ff ? -$signed({2'b0, div_rsp.quotient})
                               : $signed({2'b0, div_rsp.quotient});
   assign t_lo     = (t_lo_ff > t_hi_ff) ? t_hi_ff : t_lo_ff;
   assign t_hi     = (t_lo_ff > t_hi_ff) ? t_lo_ff : t_hi_ff;
   assign tmin_new = (t_lo > tmin_ff) ? t_lo : tmin_ff;
   assign tmax_new = (t_hi < tmax_ff) ? t_hi : tmax_ff;
   assign prod_hi  = {2'b0, prod_ff[63:16]};

   // distance and pick
   logic [64:0]   dist_sum;
   logic          better, fin_go, any_hit_new;
   logic [CW-1:0] best_idx_new;
   logic [CW+5:0] idx_wide;

   assign dist_sum     = {1'b0, dist_ff} + {1'b0, prod_ff};
   assign better       = hit_ff && (!any_hit_ff || dist_ff < best_dist_ff);
   assign fin_go       = !(last_ff && rsp_valid_ff);
   assign any_hit_new  = any_hit_ff | better;
   assign best_idx_new = better ? box_cnt_ff : best_idx_ff;
   assign idx_wide     = {6'b0, best_idx_new};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:        if (req_valid) state_in = ST_DIST_MUL;
         ST_DIST_MUL:    state_in = ST_DIST_ACC;
         ST_DIST_ACC:    state_in = (j_ff == 2'd2) ? ST_L2_MUL : ST_DIST_MUL;
         ST_L2_MUL:      state_in = ST_L2_ACC;
         ST_L2_ACC:      state_in = (j_ff == 2'd2) ? ST_SQRT : ST_L2_MUL;
         ST_SQRT:        if (sq_cnt_ff == 5'd19) state_in = ST_NORM_START;
         ST_NORM_START:  state_in = (sq_root_ff == '0) ? ST_NOM_MUL : ST_NORM_WAIT;
         ST_NORM_WAIT:   if (!div_rsp.busy) state_in = ST_NOM_MUL;
         ST_NOM_MUL:     state_in = ST_NOM_ACC;
         ST_NOM_ACC:     state_in = ST_DEN_MUL;
         ST_DEN_MUL:     state_in = ST_DEN_ACC;
         ST_DEN_ACC:     state_in = (j_ff == 2'd2) ? ST_SLAB_CHECK : ST_NORM_START;
         ST_SLAB_CHECK: begin
            if (den_big) begin
               state_in = ST_TDIV_START;
            end else if (par_miss || k_ff == 2'd2) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_L2_MUL;
            end
         end
         ST_TDIV_START: begin
            if (!t_sat) begin
               state_in = ST_TDIV_WAIT;
            end else if (side_ff) begin
               state_in = ST_SLAB_UPDATE;
            end
         end
         ST_TDIV_WAIT: begin
            if (!div_rsp.busy) begin
               state_in = side_ff ? ST_SLAB_UPDATE : ST_TDIV_START;
            end
         end
         ST_SLAB_UPDATE: begin
            if (tmax_new < tmin_new || k_ff == 2'd2) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_L2_MUL;
            end
         end
         ST_FINISH:      if (fin_go) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready        = 1'b0;
      mul_a            = '0;
      mul_b            = '0;
      div_req.start    = 1'b0;
      div_req.count    = 6'd31;
      div_req.rem_init = {28'b0, a_mag[19:1]};
      div_req.low      = {a_mag[0], 46'b0};
      div_req.divisor  = {27'b0, sq_root_ff};
      unique case (state_ff)
         ST_IDLE:       req_ready = 1'b1;
         ST_DIST_MUL: begin
            mul_a = d_mag;
            mul_b = d_mag;
         end
         ST_L2_MUL: begin
            mul_a = {12'b0, a_mag};
            mul_b = {12'b0, a_mag};
         end
         ST_NOM_MUL: begin
            mul_a = {1'b0, u_mag_ff};
            mul_b = d_mag;
         end
         ST_DEN_MUL: begin
            mul_a = {1'b0, u_mag_ff};
            mul_b = dir_mag;
         end
         ST_NORM_START: div_req.start = (sq_root_ff != '0);
         ST_TDIV_START: begin
            div_req.start    = !t_sat;
            div_req.count    = 6'd47;
            div_req.rem_init = {28'b0, n_mag[49:31]};
            div_req.low      = {n_mag[30:0], 16'b0};
            div_req.divisor  = den_mag;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         box_cnt_ff   <= '0;
         best_idx_ff  <= '0;
         best_dist_ff <= '1;
         any_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_FINISH && fin_go) begin
            if (last_ff) begin
               rsp_valid_ff <= 1'b1;
               box_cnt_ff   <= '0;
               best_idx_ff  <= '0;
               best_dist_ff <= '1;
               any_hit_ff   <= 1'b0;
            end else begin
               box_cnt_ff  <= (box_cnt_ff == LAST_IDX) ? '0 : box_cnt_ff + 1'b1;
               best_idx_ff <= best_idx_new;
               any_hit_ff  <= any_hit_new;
               if (better) begin
                  best_dist_ff <= dist_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && fin_go && last_ff) begin
         rsp_found_ff <= any_hit_new;
         rsp_index_ff <= any_hit_new ? idx_wide[5:0] : 6'd0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dx_ff   <= 33'(signed'(req_center_x)) - 33'(org_x_ff);
               dy_ff   <= 33'(signed'(req_center_y)) - 33'(org_y_ff);
               dz_ff   <= 33'(signed'(req_center_z)) - 33'(org_z_ff);
               half_ff <= req_half_extents;
               ax_r_ff <= req_axis_right;
               ax_u_ff <= req_axis_up;
               ax_f_ff <= req_axis_forward;
               last_ff <= req_last_box;
               j_ff    <= 2'd0;
               k_ff    <= 2'd0;
               dist_ff <= '0;
               l2_ff   <= '0;
               tmin_ff <= '0;
               tmax_ff <= T_LIMIT;
               hit_ff  <= 1'b1;
            end
         end
         ST_DIST_ACC: begin
            dist_ff <= dist_sum[64] ? '1 : dist_sum[63:0];
            j_ff    <= (j_ff == 2'd2) ? 2'd0 : j_ff + 2'd1;
         end
         ST_L2_ACC: begin
            if (j_ff == 2'd2) begin
               sq_rad_ff  <= l2_ff + prod_ff[39:0];
               sq_rem_ff  <= '0;
               sq_root_ff <= '0;
               sq_cnt_ff  <= '0;
               j_ff       <= 2'd0;
               nom_ff     <= '0;
               den_ff     <= '0;
            end else begin
               l2_ff <= l2_ff + prod_ff[39:0];
               j_ff  <= j_ff + 2'd1;
            end
         end
         ST_SQRT: begin
            sq_rem_ff  <= sq_ge ? 22'(sq_cand - sq_trial) : sq_cand[21:0];
            sq_root_ff <= {sq_root_ff[18:0], sq_ge};
            sq_rad_ff  <= {sq_rad_ff[37:0], 2'b00};
            sq_cnt_ff  <= sq_cnt_ff + 5'd1;
         end
         ST_NORM_START: begin
            u_neg_ff <= a_cur[19];
            u_mag_ff <= '0;
         end
         ST_NORM_WAIT: begin
            if (!div_rsp.busy) begin
               u_mag_ff <= div_rsp.quotient[30:0];
            end
         end
         ST_NOM_ACC: begin
            nom_ff <= (u_neg_ff ^ d_neg) ? nom_ff - $signed(prod_hi)
                                         : nom_ff + $signed(prod_hi);
         end
         ST_DEN_ACC: begin
            den_ff <= (u_neg_ff ^ dir_cur[31]) ? den_ff - $signed(prod_hi)
                                               : den_ff + $signed(prod_hi);
            j_ff   <= (j_ff == 2'd2) ? 2'd0 : j_ff + 2'd1;
         end
         ST_SLAB_CHECK: begin
            side_ff <= 1'b0;
            if (!den_big) begin
               if (par_miss) begin
                  hit_ff <= 1'b0;
               end else begin
                  k_ff  <= k_ff + 2'd1;
                  l2_ff <= '0;
               end
            end
         end
         ST_TDIV_START: begin
            t_neg_ff <= num_neg ^ den_ff[49];
            if (t_sat) begin
               if (side_ff) begin
                  t_hi_ff <= t_sat_val;
               end else begin
                  t_lo_ff <= t_sat_val;
                  side_ff <= 1'b1;
               end
            end
         end
         ST_TDIV_WAIT: begin
            if (!div_rsp.busy) begin
               if (side_ff) begin
                  t_hi_ff <= t_div_val;
               end else begin
                  t_lo_ff <= t_div_val;
                  side_ff <= 1'b1;
               end
            end
         end
         ST_SLAB_UPDATE: begin
            tmin_ff <= tmin_new;
            tmax_ff <= tmax_new;
            if (tmax_new < tmin_new) begin
               hit_ff <= 1'b0;
            end else begin
               k_ff  <= k_ff + 2'd1;
               l2_ff <= '0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit_found = rsp_found_ff;
   assign rsp_hit_index = rsp_index_ff;

   property p_accept_leaves_idle;
      @(posedge clock) disable iff (reset) req_valid && req_ready |=> state_ff != ST_IDLE;
   endproperty
   a_accept_leaves_idle: assert property (p_accept_leaves_idle)
      else $error("transfer accepted but sequencer stayed idle");

   property p_rsp_from_finish;
      @(posedge clock) disable iff (reset) $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH);
   endproperty
   a_rsp_from_finish: assert property (p_rsp_from_finish)
      else $error("result raised outside finish");

   property p_no_hit_zero_index;
      @(posedge clock) disable iff (reset) rsp_valid |-> rsp_hit_found || rsp_hit_index == 6'd0;
   endproperty
   a_no_hit_zero_index: assert property (p_no_hit_zero_index)
      else $error("miss reported with nonzero index");

   property p_div_idle_outside_wait;
      @(posedge clock) disable iff (reset)
         div_rsp.busy |-> state_ff == ST_NORM_WAIT || state_ff == ST_TDIV_WAIT;
   endproperty
   a_div_idle_outside_wait: assert property (p_div_idle_outside_wait)
      else $error("divider busy outside a wait state");

endmodule

/* test/ray_obb_nearest_pick_core_tb.sv */
// Testbench for ray_obb_nearest_pick_core: streams box sets against several ray settings
// and checks each nearest-hit result against an in-bench fixed-point slab predictor.
// Depends on rop_pkg and the RTL of ray_obb_nearest_pick_core.
module ray_obb_nearest_pick_core_tb import rop_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NUM_BOXES  = 64;
   localparam int  DRAIN_WAIT = 1200;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [31:0] cx, cy, cz;
      logic [59:0] half, ax_r, ax_u, ax_f;
      logic        last;
   } box_type;

   typedef struct {
      logic       hit;
      logic [5:0] idx;
   } pick_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_center_x = 0, req_center_y = 0, req_center_z = 0;
   logic [59:0] req_half_extents = 0, req_axis_right = 0, req_axis_up = 0;
   logic [59:0] req_axis_forward = 0;
   logic        req_last_box = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_hit_found;
   logic [5:0]  rsp_hit_index;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [4:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   pick_type    expected_picks[$];
   longint      ray_reg[6];
   int          set_pos;
   logic [63:0] best_dist;
   int          best_idx;
   bit          any_hit;
   bit          no_idle = 0;
   int          mismatches = 0;
   int          rsp_hold = 0;
   longint      cycles = 0;

   ray_obb_nearest_pick_core #(.MAX_BOXES(NUM_BOXES)) u_top (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [63:0] mag(longint a);
      return a < 0 ? 64'd0 - 64'(a) : 64'(a);
   endfunction

   function automatic longint sx20(logic [19:0] v);
      logic signed [19:0] s;
      s = v;
      return longint'(s);
   endfunction

   function automatic longint mul_q16(longint a, longint b);
      logic [63:0] p;
      p = (mag(a) * mag(b)) >> 16;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint slab_t(longint num, longint den);
      logic [63:0] n, d, ip, rm;
      longint q;
      n = mag(num);
      d = mag(den);
      ip = n / d;
      rm = n % d;
      if (ip >= (64'd1 << 31)) q = longint'(64'd1 << 47);
      else q = longint'((ip << 16) + ((rm << 16) / d));
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   function automatic void predict_pick(box_type b);
      longint d[3], a[3], u[3], nom, den, hq, lo, hi, tmin, tmax, tq;
      logic [63:0] l2, len, dist_acc, sq;
      logic [59:0] axv;
      logic [31:0] cv[3];
      bit hit;
      pick_type p;
      cv[0] = b.cx; cv[1] = b.cy; cv[2] = b.cz;
      for (int j = 0; j < 3; j++) d[j] = longint'($signed(cv[j])) - ray_reg[j];
      tmin = 0;
      tmax = longint'(T_LIMIT);
      hit = 1;
      for (int k = 0; k < 3 && hit; k++) begin
         axv = (k == 0) ? b.ax_r : (k == 1) ? b.ax_u : b.ax_f;
         l2 = 0;
         for (int j = 0; j < 3; j++) begin
            a[j] = sx20(axv[20*j +: 20]);
            l2 = l2 + mag(a[j]) * mag(a[j]);
         end
         len = int_sqrt(l2);
         nom = 0;
         den = 0;
         for (int j = 0; j < 3; j++) begin
            if (len == 0) u[j] = 0;
            else begin
               tq = longint'((mag(a[j]) << 30) / len);
               u[j] = a[j] < 0 ? -tq : tq;
            end
            nom = nom + mul_q16(u[j], d[j]);
            den = den + mul_q16(u[j], ray_reg[3+j]);
         end
         hq = longint'(b.half[20*k +: 20]) << 22;
         if (mag(den) > EPS_Q30) begin
            lo = slab_t(nom - hq, den);
            hi = slab_t(nom + hq, den);
            if (lo > hi) begin
               tq = lo; lo = hi; hi = tq;
            end
            if (lo > tmin) tmin = lo;
            if (hi < tmax) tmax = hi;
            if (tmax < tmin) hit = 0;
         end else if (nom < -hq || nom > hq) begin
            hit = 0;
         end
      end
      dist_acc = 0;
      for (int j = 0; j < 3; j++) begin
         sq = mag(d[j]) * mag(d[j]);
         dist_acc = (dist_acc > ~64'd0 - sq) ? ~64'd0 : dist_acc + sq;
      end
      if (hit && (!any_hit || dist_acc < best_dist)) begin
         best_dist = dist_acc;
         best_idx = set_pos;
         any_hit = 1;
      end
      set_pos = (set_pos + 1) % NUM_BOXES;
      if (b.last) begin
         p.hit = any_hit;
         p.idx = any_hit ? 6'(best_idx) : 6'd0;
         expected_picks.push_back(p);
         set_pos = 0;
         best_dist = ~64'd0;
         best_idx = 0;
         any_hit = 0;
      end
   endfunction

   // result side: random stall bursts, checked on the falling edge before the transfer edge
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
         rsp_hold <= $urandom_range(0, 8);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   always @(negedge clock) begin
      pick_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_picks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result hit=%0d idx=%0d", rsp_hit_found, rsp_hit_index);
         end else begin
            e = expected_picks.pop_front();
            if (e.hit !== rsp_hit_found || e.idx !== rsp_hit_index) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected hit=%0d idx=%0d, got hit=%0d idx=%0d",
                           e.hit, e.idx, rsp_hit_found, rsp_hit_index);
            end
         end
      end
   end

   task automatic send_box(box_type b);
      bit ok;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1;
      req_center_x <= b.cx;
      req_center_y <= b.cy;
      req_center_z <= b.cz;
      req_half_extents <= b.half;
      req_axis_right <= b.ax_r;
      req_axis_up <= b.ax_u;
      req_axis_forward <= b.ax_f;
      req_last_box <= b.last;
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
      predict_pick(b);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_ray(longint ox, longint oy, longint oz,
                            longint dx, longint dy, longint dz);
      longint v[6];
      v = '{ox, oy, oz, dx, dy, dz};
      drain();
      for (int i = 0; i < 6; i++) begin
         psel <= 1;
         penable <= 0;
         pwrite <= 1;
         paddr <= 5'(4 * csr_index_type'(i));
         pwdata <= 32'(v[i]);
         @(posedge clock);
         penable <= 1;
         @(posedge clock);
         ray_reg[i] = longint'($signed(32'(v[i])));
      end
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      @(posedge clock);
   endtask

   function automatic logic [59:0] pack3(longint x, longint y, longint z);
      return {20'(z), 20'(y), 20'(x)};
   endfunction

   function automatic box_type mk(longint x, longint y, longint z, logic [59:0] h,
                                  logic [59:0] r, logic [59:0] u, logic [59:0] f, bit l);
      box_type b;
      b.cx = 32'(x); b.cy = 32'(y); b.cz = 32'(z);
      b.half = h; b.ax_r = r; b.ax_u = u; b.ax_f = f; b.last = l;
      return b;
   endfunction

   function automatic box_type random_box(bit last);
      box_type b;
      int k;
      if ($urandom_range(0, 9) < 7) begin
         // box placed along the ray, axes random, extents large
         k = $urandom_range(0, 12);
         b.cx = 32'(ray_reg[0] + ray_reg[3] * k + $signed($urandom_range(0, 262143)) - 131072);
         b.cy = 32'(ray_reg[1] + ray_reg[4] * k + $signed($urandom_range(0, 262143)) - 131072);
         b.cz = 32'(ray_reg[2] + ray_reg[5] * k + $signed($urandom_range(0, 262143)) - 131072);
         b.half = {20'($urandom), 20'($urandom), 20'($urandom)} | {3{20'h0f000}};
      end else begin
         b.cx = $urandom;
         b.cy = $urandom;
         b.cz = $urandom;
         b.half = {28'($urandom), $urandom};
      end
      b.ax_r = {28'($urandom), $urandom};
      b.ax_u = {28'($urandom), $urandom};
      b.ax_f = {28'($urandom), $urandom};
      b.last = last;
      return b;
   endfunction

   task automatic test_zero_and_extremes();
      logic [59:0] ones = '1;
      write_ray(0, 0, 0, 0, 0, 0);
      send_box(mk(0, 0, 0, 0, 0, 0, 0, 1));
      send_box(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, ones, ones, ones, ones, 1));
      send_box(mk(32'h80000000, 32'h80000000, 32'h80000000, 0,
                  {3{20'h80000}}, {3{20'h80000}}, {3{20'h80000}}, 1));
      write_ray(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_box(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, ones,
                  pack3(65536, 0, 0), pack3(0, 65536, 0), pack3(0, 0, 65536), 0));
      send_box(mk(0, 0, 0, ones, ones, ones, ones, 0));
      send_box(mk(32'h80000000, 32'h80000000, 32'h80000000, ones,
                  pack3(65536, 0, 0), pack3(0, 65536, 0), pack3(0, 0, 65536), 1));
   endtask

   task automatic test_parallel_and_far_slab();
      logic [59:0] idr = pack3(65536, 0, 0), idu = pack3(0, 65536, 0);
      logic [59:0] idf = pack3(0, 0, 65536);
      write_ray(0, 0, 0, 65536, 0, 0);
      // y slab parallel to the ray: inside, then outside the extent
      send_box(mk(10 << 16, 1 << 16, 0, {3{20'd512}}, idr, idu, idf, 0));
      send_box(mk(10 << 16, 3 << 16, 0, {3{20'd512}}, idr, idu, idf, 1));
      // box behind the origin
      send_box(mk(-(10 << 16), 0, 0, {3{20'd512}}, idr, idu, idf, 1));
      // tiny direction just above the parallel threshold: slab distance saturates
      write_ray(0, 0, 0, 1, 0, 0);
      send_box(mk(32'h7fff0000, 0, 0, {3{20'd256}}, idr, idu, idf, 1));
      send_box(mk(2 << 16, 0, 0, {3{20'd256}}, idr, idu, idf, 1));
   endtask

   task automatic test_distance_ties();
      logic [59:0] idr = pack3(65536, 0, 0), idu = pack3(0, 65536, 0);
      logic [59:0] idf = pack3(0, 0, 65536);
      write_ray(5 << 16, -(3 << 16), 7 << 16, 0, 65536, 0);
      send_box(mk(5 << 16, 20 << 16, 7 << 16, {3{20'd1024}}, idr, idu, idf, 0));
      send_box(mk(5 << 16, 20 << 16, 7 << 16, {3{20'd1024}}, idr, idu, idf, 0));
      send_box(mk(5 << 16, 4 << 16, 7 << 16, {3{20'd1024}}, idr, idu, idf, 0));
      send_box(mk(5 << 16, 40 << 16, 7 << 16, {3{20'd1024}}, idr, idu, idf, 1));
      // very distant centres saturate the distance
      write_ray(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
      send_box(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, '1, 0, 0, 0, 0));
      send_box(mk(32'h7ffffff0, 32'h7fffffff, 32'h7fffffff, '1, 0, 0, 0, 1));
   endtask

   task automatic test_random_sets(int total);
      int sent, n;
      sent = 0;
      while (sent < total) begin
         if (sent % 100 == 0) begin
            if ($urandom_range(0, 3) == 0)
               write_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
               write_ray($signed($urandom_range(0, 2097151)) - 1048576,
                         $signed($urandom_range(0, 2097151)) - 1048576,
                         $signed($urandom_range(0, 2097151)) - 1048576,
                         $signed($urandom_range(0, 262143)) - 131072,
                         $signed($urandom_range(0, 262143)) - 131072,
                         $signed($urandom_range(0, 262143)) - 131072);
         end
         if (sent >= total - 80) no_idle = 1;
         n = ($urandom_range(0, 30) == 0) ? 70 : $urandom_range(1, 8);
         for (int i = 0; i < n; i++) send_box(random_box(i == n - 1));
         sent += n;
      end
   endtask

   initial begin
      set_pos = 0;
      best_dist = '1;
      best_idx = 0;
      any_hit = 0;
      foreach (ray_reg[i]) ray_reg[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_zero_and_extremes();
      test_parallel_and_far_slab();
      test_distance_ties();
      test_random_sets(500);
      drain();
      if (mismatches == 0 && expected_picks.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/rop_pkg.sv
hw/rtl/rop_div.sv
hw/rtl/ray_obb_nearest_pick_core.sv
test/ray_obb_nearest_pick_core_tb.sv
